// ===== hw/rtl/bitmap_block_allocator_core_defines.svh =====
// Assertion macros shared by the allocator RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset.
`define BBA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication, checked outside reset.
`define BBA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`else

`define BBA_ASSERT_IMP(label, ante, cons)
`define BBA_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/bba_pkg.sv =====
package bba_pkg;

    // Field and register widths.
    localparam int BLOCK_W = 10;
    localparam int COUNT_W = 11;
    localparam int STATUS_W = 2;
    localparam int WORD_W = 6;
    localparam int MARK_W = 32;
    localparam int POS_W = 5;

    // Request types.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // Register map: index taken from paddr[2].
    localparam logic REG_BLK_COUNT = 1'b0;
    localparam logic [COUNT_W-1:0] BLK_COUNT_RESET = 11'd1024;

    // Largest block count the 11-bit register can ask for.
    localparam int MAX_COUNT = 2047;

    // Mark memory access issued by the sequencer.
    typedef struct packed {
        logic              rd_en;
        logic [WORD_W-1:0] rd_addr;
        logic              wr_en;
        logic [WORD_W-1:0] wr_addr;
        logic [MARK_W-1:0] wr_data;
    } mem_req_t;

endpackage

// ===== hw/rtl/bba_req_if.sv =====
interface bba_req_if;
    logic                           valid;
    logic                           ready;
    logic                           req_type;
    logic [bba_pkg::BLOCK_W-1:0]    block_number;

    modport source (output valid, output req_type, output block_number, input ready);
    modport sink (input valid, input req_type, input block_number, output ready);
endinterface

// ===== hw/rtl/bba_res_if.sv =====
interface bba_res_if;
    logic                           valid;
    logic                           ready;
    logic [bba_pkg::STATUS_W-1:0]   status;
    logic [bba_pkg::BLOCK_W-1:0]    allocated_block;

    modport source (output valid, output status, output allocated_block, input ready);
    modport sink (input valid, input status, input allocated_block, output ready);
endinterface

// ===== hw/rtl/bba_mark_mem.sv =====
module bba_mark_mem #(
    parameter int WORDS = 32,
    parameter int AW = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bba_pkg::mem_req_t             mem_req,
    output logic [bba_pkg::MARK_W-1:0]    rd_data
);
    import bba_pkg::*;

    logic [MARK_W-1:0] mem_q [WORDS];
    logic [WORDS-1:0]  word_vld_reg;
    logic [MARK_W-1:0] rd_word_reg;
    logic              rd_vld_reg;

    // Per-word valid bits: a word never written reads as all free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_vld_reg <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (mem_req.wr_en)
            begin
                word_vld_reg[mem_req.wr_addr[AW-1:0]] <= 1'b1;
            end
            if (mem_req.rd_en)
            begin
                rd_vld_reg <= word_vld_reg[mem_req.rd_addr[AW-1:0]];
            end
        end
    end

    // Single write port and single registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem_q[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_word_reg <= mem_q[mem_req.rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_vld_reg ? rd_word_reg : '0;

endmodule

// ===== hw/rtl/bba_ctrl.sv =====
`include "bitmap_block_allocator_core_defines.svh"

module bba_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    bba_req_if.sink                        req,
    bba_res_if.source                      res,
    input  logic [bba_pkg::COUNT_W-1:0]    limit,
    output bba_pkg::mem_req_t              mem_req,
    input  logic [bba_pkg::MARK_W-1:0]     rd_data
);
    import bba_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_FREE_MOD = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;

    logic [2:0]          state_reg, state_next;
    logic                wr_pend_reg, wr_pend_next;
    logic                res_vld_reg, res_vld_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic [POS_W-1:0]    bit_reg, bit_next;
    logic [MARK_W-1:0]   wdata_reg, wdata_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [BLOCK_W-1:0]  got_reg, got_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [BLOCK_W-1:0]  res_block_reg, res_block_next;

    logic                accept;
    logic                out_free;
    logic [COUNT_W-1:0]  lim_m1;
    logic [WORD_W-1:0]   last_word;
    logic [MARK_W-1:0]   tail_mask;
    logic [MARK_W-1:0]   free_vec;
    logic [POS_W-1:0]    free_pos;
    logic                found;

    assign accept = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free = !res_vld_reg || res.ready;

    // Last word that holds blocks below the limit, and its in-range bits.
    assign lim_m1 = limit - COUNT_W'(1);
    assign last_word = lim_m1[COUNT_W-1:POS_W];
    assign tail_mask = (limit[POS_W-1:0] == '0) ? '1
                     : ((MARK_W'(1) << limit[POS_W-1:0]) - MARK_W'(1));

    // Free blocks of the word under test; bits past the limit count as used.
    assign free_vec = ~rd_data & ((word_reg == last_word) ? tail_mask : '1);
    assign found = |free_vec;

    // Lowest free bit of the word.
    always_comb
    begin
        free_pos = '0;
        for (int i = MARK_W - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                free_pos = POS_W'(i);
            end
        end
    end

    // Sequencer: accept, scan or modify one word, then write back and report.
    always_comb
    begin
        state_next = state_reg;
        wr_pend_next = wr_pend_reg;
        res_vld_next = res_vld_reg;
        word_next = word_reg;
        bit_next = bit_reg;
        wdata_next = wdata_reg;
        status_next = status_reg;
        got_next = got_reg;
        res_status_next = res_status_reg;
        res_block_next = res_block_reg;
        mem_req = '0;

        if (res_vld_reg && res.ready)
        begin
            res_vld_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    got_next = '0;
                    wr_pend_next = 1'b0;
                    if (req.req_type == REQ_ALLOC)
                    begin
                        if (limit == '0)
                        begin
                            status_next = ST_NOFREE;
                            state_next = S_WRITE;
                        end
                        else
                        begin
                            mem_req.rd_en = 1'b1;
                            mem_req.rd_addr = '0;
                            word_next = '0;
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (COUNT_W'(req.block_number) >= limit)
                        begin
                            status_next = ST_RANGE;
                            state_next = S_WRITE;
                        end
                        else
                        begin
                            mem_req.rd_en = 1'b1;
                            mem_req.rd_addr = WORD_W'(req.block_number[BLOCK_W-1:POS_W]);
                            word_next = WORD_W'(req.block_number[BLOCK_W-1:POS_W]);
                            bit_next = req.block_number[POS_W-1:0];
                            state_next = S_FREE_MOD;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (found)
                begin
                    wdata_next = rd_data | (MARK_W'(1) << free_pos);
                    wr_pend_next = 1'b1;
                    got_next = BLOCK_W'({word_reg, free_pos});
                    status_next = ST_OK;
                    state_next = S_WRITE;
                end
                else if (word_reg == last_word)
                begin
                    status_next = ST_NOFREE;
                    state_next = S_WRITE;
                end
                else
                begin
                    // Read of the next word overlaps the test of this one.
                    mem_req.rd_en = 1'b1;
                    mem_req.rd_addr = word_reg + WORD_W'(1);
                    word_next = word_reg + WORD_W'(1);
                end
            end

            S_FREE_MOD:
            begin
                wdata_next = rd_data & ~(MARK_W'(1) << bit_reg);
                wr_pend_next = 1'b1;
                status_next = ST_OK;
                state_next = S_WRITE;
            end

            S_WRITE:
            begin
                // Write-back lands before the next item can read.
                if (out_free)
                begin
                    mem_req.wr_en = wr_pend_reg;
                    mem_req.wr_addr = word_reg;
                    mem_req.wr_data = wdata_reg;
                    res_vld_next = 1'b1;
                    res_status_next = status_reg;
                    res_block_next = got_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wr_pend_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wr_pend_reg <= wr_pend_next;
            res_vld_reg <= res_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        bit_reg <= bit_next;
        wdata_reg <= wdata_next;
        status_reg <= status_next;
        got_reg <= got_next;
        res_status_reg <= res_status_next;
        res_block_reg <= res_block_next;
    end

    assign res.valid = res_vld_reg;
    assign res.status = res_status_reg;
    assign res.allocated_block = res_block_reg;

    // The memory is written only from the write-back step.
    `BBA_ASSERT_IMP(a_wr_only_in_write, mem_req.wr_en, state_reg == S_WRITE)
    // The scan never reads past the last word below the limit.
    `BBA_ASSERT_IMP(a_scan_in_range, (state_reg == S_SCAN) && mem_req.rd_en, word_reg < last_word)
    // A successful result names a block below the limit.
    `BBA_ASSERT_IMP(a_ok_below_limit, res_vld_reg && (res_status_reg == ST_OK), COUNT_W'(res_block_reg) < limit)
    // A new result is loaded only from the write-back step.
    `BBA_ASSERT_IMP(a_res_from_write, $rose(res_vld_reg), $past(state_reg) == S_WRITE)

endmodule

// ===== hw/rtl/bitmap_block_allocator_core.sv =====
// Bitmap first-fit block allocator. An allocate request returns the lowest free
// block below the block count register (capped at NUM_BLOCKS) and marks it used; a
// free request clears the named block's mark. The marks sit in a 32-bit-wide
// single-port-read memory, one word per 32 blocks. One request is handled at a time:
// an allocate reads words in order until a free block is found, at most
// ceil(active count / 32) of them; the scan tests one memory word per cycle with
// the next read overlapped. A free reads, modifies and writes back its word, and
// requests that fail the range or count check go straight to write-back. A result
// still waiting for ready holds the next request in its write-back step until that
// beat goes out, and the next request can be accepted in the same cycle that a
// result is raised. Each word has a valid bit cleared by reset, so the allocator
// is ready right after reset with no clearing pass.
module bitmap_block_allocator_core #(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    bba_req_if.sink                        req,
    bba_res_if.source                      res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import bba_pkg::*;

    localparam int CAP = (NUM_BLOCKS < MAX_COUNT) ? NUM_BLOCKS : MAX_COUNT;
    localparam int WORDS = (CAP + MARK_W - 1) / MARK_W;
    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAP);

    logic [COUNT_W-1:0] blk_count_reg;
    logic [COUNT_W-1:0] limit;
    logic               cfg_wr;
    mem_req_t           mem_req;
    logic [MARK_W-1:0]  rd_data;

    // Configuration register write.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BLK_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_count_reg <= BLK_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            blk_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_BLK_COUNT) ? 32'(blk_count_reg) : '0;

    // Active count is the register limited to the store size.
    assign limit = (blk_count_reg > CAP_COUNT) ? CAP_COUNT : blk_count_reg;

    bba_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .res     (res),
        .limit   (limit),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    bba_mark_mem #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

endmodule

// ===== verif/allocator_checker.sv =====
// Watches the request, result and register channels of the allocator, keeps its
// own copy of the used marks and the block count, and compares every result beat
// with the outcome predicted for the oldest request still waiting.
module allocator_checker
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    bba_req_if          req,
    bba_res_if          res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BLOCK_W-1:0]  block;
    } outcome_t;

    // Only the first PRINT_LIMIT mismatches are printed; all of them are counted.
    localparam int PRINT_LIMIT = 50;

    logic               used_map [NUM_BLOCKS];
    logic [COUNT_W-1:0] block_count = BLK_COUNT_RESET;
    outcome_t           awaited_outcomes [$];
    int                 mismatch_count = 0;
    int                 waiting_count = 0;

    assign mismatches = mismatch_count;
    assign outstanding = waiting_count;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
        begin
            $display("[%0t] allocator check: %s", $time, msg);
        end
    endtask

    // Applies one request to the local mark store and returns its result.
    function automatic outcome_t predict_outcome(input logic kind,
                                                 input logic [BLOCK_W-1:0] num);
        int       limit;
        outcome_t result;
        // The scan and range limit never exceed the size of the store.
        limit = (int'(block_count) > NUM_BLOCKS) ? NUM_BLOCKS : int'(block_count);
        result.status = ST_OK;
        result.block = '0;
        if (kind == REQ_ALLOC)
        begin
            // First fit: lowest free block below the limit.
            result.status = ST_NOFREE;
            for (int b = 0; b < limit; b++)
            begin
                if (!used_map[b])
                begin
                    used_map[b] = 1'b1;
                    result.block = b[BLOCK_W-1:0];
                    result.status = ST_OK;
                    break;
                end
            end
        end
        else if (int'(num) >= limit)
        begin
            result.status = ST_RANGE;
        end
        else
        begin
            used_map[num] = 1'b0;
        end
        return result;
    endfunction

    // Values are taken as they stood just before each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BLOCKS; b++)
            begin
                used_map[b] = 1'b0;
            end
            block_count = BLK_COUNT_RESET;
            awaited_outcomes.delete();
            waiting_count = 0;
        end
        else
        begin
            // Result beat: compare with the oldest prediction.
            if (res.valid && res.ready)
            begin
                if (awaited_outcomes.size() == 0)
                begin
                    report_mismatch($sformatf("result beat with no request waiting (status %0d)",
                                              res.status));
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (res.status !== want.status)
                    begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  res.status, want.status));
                    end
                    if (res.allocated_block !== want.block)
                    begin
                        report_mismatch($sformatf("allocated_block %0d, expected %0d",
                                                  res.allocated_block, want.block));
                    end
                end
            end

            // Register write; addresses beyond the register list are ignored.
            if (psel && penable && pwrite && pready && paddr[2] == REG_BLK_COUNT)
            begin
                block_count = pwdata[COUNT_W-1:0];
            end

            // Request beat: predict its result now, in acceptance order.
            if (req.valid && req.ready)
            begin
                awaited_outcomes.push_back(predict_outcome(req.req_type, req.block_number));
            end
            waiting_count = awaited_outcomes.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
module tb;
    import bba_pkg::*;

    localparam int NUM_BLOCKS = 1024;
    localparam int IDLE_LIMIT = 4000;
    localparam int PHASE_ITEMS = 115;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [2:0] BLK_COUNT_ADDR = {REG_BLK_COUNT, 2'b00};
    localparam logic [2:0] UNMAPPED_ADDR = 3'd4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        sink_ready = 1'b0;
    logic [7:0]  stall_pattern = 8'hff;
    int          stall_step = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    logic        no_gaps = 1'b0;
    int          mismatches;
    int          outstanding;

    bba_req_if req ();
    bba_res_if res ();

    assign res.ready = sink_ready;

    bitmap_block_allocator_core #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .res     (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    allocator_checker #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) alloc_watch (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .res         (res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result side: ready follows an 8-bit pattern, redrawn whenever stall_step wraps to
    // zero. At least a quarter of the patterns never stall; bit 0 is always set.
    always @(posedge clk)
    begin
        if (stall_step == 0)
        begin
            stall_pattern <= ($urandom_range(0, 3) == 0) ? 8'hff : (8'($urandom()) | 8'h01);
        end
        stall_step <= (stall_step + 1) % 64;
        sink_ready <= stall_pattern[stall_step % 8];
    end

    // Watchdog: too long without any beat on any channel ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (res.valid && res.ready)
            || (psel && penable && pready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("bitmap_block_allocator_core: mismatch");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one request and returns at the edge where it is accepted.
    task automatic send_request(input logic kind, input logic [BLOCK_W-1:0] num);
        req.valid <= 1'b1;
        req.req_type <= kind;
        req.block_number <= num;
        @(negedge clk);
        while (!req.ready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    // Sends a request as part of a burst, with a random gap before each burst.
    task automatic paced_request(input logic kind, input logic [BLOCK_W-1:0] num);
        int gap;
        if (burst_left == 0)
        begin
            gap = no_gaps ? 0 : $urandom_range(0, 15);
            if (gap != 0)
            begin
                // Valid may already be low after a drain.
                if (req.valid)
                begin
                    req.valid <= 1'b0;
                end
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        send_request(kind, num);
    endtask

    // Stops sending until every predicted result has been returned.
    task automatic wait_drained();
        req.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    // Setup and access phases, then an idle phase on the register bus.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // One random phase at a given block count. The first half leans one way
    // between allocate and free, the second half the other way.
    task automatic run_phase(input int count, input int items);
        int                 span;
        int                 alloc_pct;
        logic               kind;
        logic [BLOCK_W-1:0] num;
        wait_drained();
        write_reg(BLK_COUNT_ADDR, count);
        span = (count < 1) ? 1 : ((count > NUM_BLOCKS) ? NUM_BLOCKS : count);
        alloc_pct = $urandom_range(35, 85);
        no_gaps = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < items; i++)
        begin
            if (i == items / 2)
            begin
                alloc_pct = 100 - alloc_pct;
            end
            kind = ($urandom_range(0, 99) < alloc_pct) ? REQ_ALLOC : REQ_FREE;
            // Mostly blocks near the active range, sometimes any block at all.
            if ($urandom_range(0, 3) == 0)
            begin
                num = BLOCK_W'($urandom());
            end
            else
            begin
                num = BLOCK_W'($urandom_range(0, span));
            end
            if ($urandom_range(0, 49) == 0)
            begin
                wait_drained();
            end
            paced_request(kind, num);
        end
    endtask

    initial
    begin
        req.valid <= 1'b0;
        req.req_type <= REQ_ALLOC;
        req.block_number <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Lowest free block first, a freed block is handed out again, and
        // freeing a block that is already free is fine.
        send_request(REQ_ALLOC, '0);
        send_request(REQ_ALLOC, '1);
        send_request(REQ_ALLOC, '0);
        send_request(REQ_FREE, 10'd1);
        send_request(REQ_ALLOC, '0);
        send_request(REQ_FREE, 10'd1023);
        send_request(REQ_FREE, 10'd0);
        send_request(REQ_ALLOC, '1);

        // Small count: store full, and frees at or above the count are rejected.
        wait_drained();
        write_reg(BLK_COUNT_ADDR, 32'd3);
        send_request(REQ_ALLOC, '0);
        send_request(REQ_FREE, 10'd3);
        send_request(REQ_FREE, 10'd1023);

        // Zero count: nothing to allocate, nothing in range.
        wait_drained();
        write_reg(BLK_COUNT_ADDR, 32'd0);
        send_request(REQ_ALLOC, '0);
        send_request(REQ_FREE, 10'd0);

        // Largest register value is limited to the size of the store.
        wait_drained();
        write_reg(BLK_COUNT_ADDR, 32'd2047);
        send_request(REQ_ALLOC, '0);
        send_request(REQ_FREE, 10'd1023);

        // A write to an address beyond the register list changes nothing.
        wait_drained();
        write_reg(UNMAPPED_ADDR, 32'd5);
        send_request(REQ_ALLOC, '0);

        // Lowered count hides used blocks above it; raising it brings them back.
        wait_drained();
        write_reg(BLK_COUNT_ADDR, 32'd2);
        send_request(REQ_ALLOC, '0);
        send_request(REQ_FREE, 10'd4);
        wait_drained();
        write_reg(BLK_COUNT_ADDR, 32'hffff_fc00 | 32'd1024);
        send_request(REQ_FREE, 10'd4);
        send_request(REQ_ALLOC, '0);

        // Random phases over several block counts, the extremes among them.
        run_phase(2047, PHASE_ITEMS);
        run_phase(1, PHASE_ITEMS);
        run_phase(33, PHASE_ITEMS);
        run_phase(0, 30);
        run_phase(64, PHASE_ITEMS);
        run_phase(1024, PHASE_ITEMS);
        run_phase($urandom_range(2, 200), PHASE_ITEMS);
        run_phase($urandom_range(1, 1024), PHASE_ITEMS);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("bitmap_block_allocator_core: match");
        end
        else
        begin
            $display("bitmap_block_allocator_core: mismatch");
        end
        $finish;
    end

endmodule
